FILE: hw/rtl/svm_pkg.sv
// Shared types and constants for the syslog message validator.
package svm_pkg;

  // Input queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_APP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROCID = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MSGID  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SDNAME = 3'd4;

  // Register reset values
  localparam logic [7:0] HOST_RST   = 8'd255;
  localparam logic [7:0] APP_RST    = 8'd48;
  localparam logic [7:0] PROCID_RST = 8'd128;
  localparam logic [7:0] MSGID_RST  = 8'd32;
  localparam logic [7:0] SDNAME_RST = 8'd32;

  // One classified message byte as it sits in the queue
  typedef struct packed {
    logic [7:0] msg_byte;
    logic       is_last;
    logic       is_dig;
    logic       is_print;
  } item_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } qstat_t;

endpackage

FILE: hw/rtl/svm_ifs.sv
// Channel interfaces: message bytes, results and configuration writes.
interface svm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       is_last;
  modport source (output valid, msg_byte, is_last, input ready);
  modport sink (input valid, msg_byte, is_last, output ready);
endinterface

interface svm_out_if;
  logic valid;
  logic ready;
  logic valid_res;
  modport source (output valid, valid_res, input ready);
  modport sink (input valid, valid_res, output ready);
endinterface

interface svm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [svm_pkg::CFG_IDX_W-1:0]  index;
  logic [7:0]                     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/svm_front.sv
// Front end: accepts message beats, classifies each byte, queues it.
module svm_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  input  logic                  pop,
  output svm_pkg::item_t        head,
  output svm_pkg::qstat_t       stat
);

  svm_pkg::item_t                  q [svm_pkg::QDEPTH];
  logic [svm_pkg::QPTR_W-1:0]      wr_ptr;
  logic [svm_pkg::QPTR_W-1:0]      rd_ptr;
  logic [svm_pkg::QCNT_W-1:0]      count;
  logic                            push;
  svm_pkg::item_t                  cls;

  // Byte classification
  always_comb begin
    cls.msg_byte = in_byte;
    cls.is_last  = in_last;
    cls.is_dig   = (in_byte >= 8'h30) && (in_byte <= 8'h39);
    cls.is_print = (in_byte >= 8'h21) && (in_byte <= 8'h7E);
  end

  assign stat.count = count;
  assign stat.full  = (count == svm_pkg::QCNT_W'(svm_pkg::QDEPTH));
  assign stat.empty = (count == '0);
  assign in_ready   = !stat.full;
  assign push       = in_valid && in_ready;
  assign head       = q[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/svm_core.sv
// Back end: per-byte syslog grammar checker, config registers, result register.
module svm_core #(
  parameter int unsigned LONGEST_FIELD = 255
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [svm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                   cfg_data,
  input  logic                         head_valid,
  input  svm_pkg::item_t               head,
  output logic                         pop,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic                         res_value
);

  localparam logic [7:0] LONG_LIM = 8'(LONGEST_FIELD);

  typedef enum logic [2:0] {
    F_PRI, F_VER, F_TIME, F_HOST, F_APP, F_PROCID, F_MSGID, F_DATA
  } field_t;

  typedef enum logic [2:0] {
    DM_START, DM_DASH, DM_ACCEPT, DM_PREFIX, DM_PNAME, DM_PEQ, DM_VALUE, DM_BAD
  } dmode_t;

  // Timestamp phases
  localparam logic [2:0] TS_NIL   = 3'd1;
  localparam logic [2:0] TS_FRAC  = 3'd2;
  localparam logic [2:0] TS_OFS   = 3'd3;
  localparam logic [2:0] TS_DONE  = 3'd4;

  logic [7:0] host_max, app_max, procid_max, msgid_max, sdname_max;

  field_t     fidx, fidx_next;
  logic [7:0] fpos, fpos_next;
  logic [2:0] hsub, hsub_next;
  logic [7:0] pval, pval_next;
  dmode_t     dmode, dmode_next;
  logic       flb, flb_next, flz, flz_next, flq, flq_next;
  logic [7:0] nlen, nlen_next;
  logic       failed, failed_next;

  logic [7:0]  c;
  logic [3:0]  d;
  logic [7:0]  hlim, sdlim, lim_raw;
  logic [11:0] pv10;
  logic        ok, bs_q, bs_nb, bs_nz;
  logic [7:0]  bs_nm;
  logic        end_ok;

  assign c   = head.msg_byte;
  assign d   = c[3:0];
  assign pop = head_valid && (!res_valid || res_ready);

  // Field length limits, clamped to the longest field
  always_comb begin
    unique case (fidx)
      F_HOST:   lim_raw = host_max;
      F_APP:    lim_raw = app_max;
      F_PROCID: lim_raw = procid_max;
      default:  lim_raw = msgid_max;
    endcase
    hlim  = (lim_raw > LONG_LIM) ? LONG_LIM : lim_raw;
    sdlim = (sdname_max > LONG_LIM) ? LONG_LIM : sdname_max;
  end

  // Bracket-block tracker shared by prefix and value modes
  always_comb begin
    bs_q  = (dmode == DM_VALUE) && flq;
    bs_nb = (c == 8'h5D) && ((nlen != '0) || bs_q);
    bs_nz = flb && (c == 8'h5B);
    if (flz) bs_nm = (sdlim != '0) ? 8'd1 : 8'd0;
    else if ((nlen != '0) && (nlen < sdlim)) bs_nm = nlen + 8'd1;
    else bs_nm = '0;
  end

  // One grammar step
  always_comb begin
    fidx_next   = fidx;
    fpos_next   = fpos;
    hsub_next   = hsub;
    pval_next   = pval;
    dmode_next  = dmode;
    flb_next    = flb;
    flz_next    = flz;
    flq_next    = flq;
    nlen_next   = nlen;
    failed_next = failed;
    ok          = 1'b0;
    pv10        = 12'(pval) * 12'd10 + 12'(d);

    if (!failed) begin
      if (c == 8'h00) begin
        failed_next = 1'b1;
      end else begin
        unique case (fidx)
          // Priority in angle brackets
          F_PRI: begin
            if (fpos == '0) begin
              if (c == 8'h3C) fpos_next = 8'd1; else failed_next = 1'b1;
            end else if (c == 8'h3E) begin
              if (hsub != '0) begin
                fidx_next = F_VER; fpos_next = '0; hsub_next = '0; nlen_next = '0;
              end else failed_next = 1'b1;
            end else if (head.is_dig) begin
              if (hsub == '0) begin
                pval_next = 8'(d); hsub_next = 3'd1;
              end else if (hsub >= 3'd3 || pval == '0) failed_next = 1'b1;
              else if (pv10 > 12'd191) failed_next = 1'b1;
              else begin
                pval_next = pv10[7:0]; hsub_next = hsub + 3'd1;
              end
            end else failed_next = 1'b1;
          end
          // Version
          F_VER: begin
            if (head.is_dig) begin
              if ((fpos == '0 && c == 8'h30) || fpos >= 8'd3) failed_next = 1'b1;
              else fpos_next = fpos + 8'd1;
            end else if (c == 8'h20 && fpos != '0) begin
              fidx_next = F_TIME; fpos_next = '0; hsub_next = '0; nlen_next = '0;
            end else failed_next = 1'b1;
          end
          // Timestamp
          F_TIME: begin
            if (hsub == TS_NIL || hsub == TS_DONE) begin
              if (c == 8'h20) begin
                fidx_next = F_HOST; fpos_next = '0; hsub_next = '0; nlen_next = '0;
              end else failed_next = 1'b1;
            end else if (hsub == TS_FRAC) begin
              if (head.is_dig && nlen < 8'd6) nlen_next = nlen + 8'd1;
              else if (nlen != '0 && c == 8'h5A) hsub_next = TS_DONE;
              else if (nlen != '0 && (c == 8'h2B || c == 8'h2D)) begin
                hsub_next = TS_OFS; nlen_next = '0;
              end else failed_next = 1'b1;
            end else if (hsub == TS_OFS) begin
              priority case (nlen)
                8'd0:    ok = c >= 8'h30 && c <= 8'h32;
                8'd1:    ok = head.is_dig && (pval != 8'd2 || c <= 8'h33);
                8'd2:    ok = c == 8'h3A;
                8'd3:    ok = c >= 8'h30 && c <= 8'h35;
                default: ok = head.is_dig;
              endcase
              if (!ok) failed_next = 1'b1;
              else begin
                pval_next = 8'(d);
                if (nlen >= 8'd4) hsub_next = TS_DONE; else nlen_next = nlen + 8'd1;
              end
            end else if (fpos == '0 && c == 8'h2D) begin
              hsub_next = TS_NIL;
            end else if (fpos == 8'd19) begin
              if (c == 8'h2E) begin hsub_next = TS_FRAC; nlen_next = '0; end
              else if (c == 8'h5A) hsub_next = TS_DONE;
              else if (c == 8'h2B || c == 8'h2D) begin
                hsub_next = TS_OFS; nlen_next = '0;
              end else failed_next = 1'b1;
            end else begin
              unique case (fpos)
                8'd4, 8'd7:   ok = c == 8'h2D;
                8'd5:         ok = c == 8'h30 || c == 8'h31;
                8'd6:         ok = head.is_dig && ((pval == '0) ? c != 8'h30 : c <= 8'h32);
                8'd8:         ok = c >= 8'h30 && c <= 8'h33;
                8'd9:         ok = head.is_dig && (pval != 8'd3 || c <= 8'h31);
                8'd10:        ok = c == 8'h54;
                8'd11:        ok = c >= 8'h30 && c <= 8'h32;
                8'd12:        ok = head.is_dig && (pval != 8'd2 || c <= 8'h33);
                8'd13, 8'd16: ok = c == 8'h3A;
                8'd14, 8'd17: ok = c >= 8'h30 && c <= 8'h35;
                default:      ok = head.is_dig;
              endcase
              if (!ok) failed_next = 1'b1;
              else begin
                pval_next = 8'(d); fpos_next = fpos + 8'd1;
              end
            end
          end
          // Structured data and message text
          F_DATA: begin
            unique case (dmode)
              DM_START: begin
                if (c == 8'h2D) begin
                  dmode_next = DM_DASH; {flb_next, flz_next, flq_next} = '0; nlen_next = '0;
                end else if (c == 8'h5B) begin
                  dmode_next = DM_PREFIX; {flb_next, flz_next, flq_next} = 3'b010;
                  nlen_next = '0;
                end else failed_next = 1'b1;
              end
              DM_DASH: begin
                if (c == 8'h20) begin
                  dmode_next = DM_ACCEPT; {flb_next, flz_next, flq_next} = '0; nlen_next = '0;
                end else failed_next = 1'b1;
              end
              DM_ACCEPT: ;
              DM_PREFIX: begin
                if (c == 8'h20) begin
                  if (flb) begin
                    dmode_next = DM_ACCEPT; {flb_next, flz_next, flq_next} = '0;
                    nlen_next = '0;
                  end else if (nlen != '0) begin
                    dmode_next = DM_PNAME; {flb_next, flz_next, flq_next} = '0;
                    nlen_next = '0;
                  end else failed_next = 1'b1;
                end else if (c == 8'h3D || c == 8'h22) failed_next = 1'b1;
                else begin
                  flb_next = bs_nb; flz_next = bs_nz; flq_next = 1'b0; nlen_next = bs_nm;
                  if (!(bs_nb || bs_nz || bs_nm != '0)) failed_next = 1'b1;
                end
              end
              DM_PNAME: begin
                if (c == 8'h3D && nlen != '0) begin
                  dmode_next = DM_PEQ; {flb_next, flz_next, flq_next} = '0; nlen_next = '0;
                end else if (c == 8'h20 || c == 8'h22 || c == 8'h3D) failed_next = 1'b1;
                else if (nlen < sdlim) nlen_next = nlen + 8'd1;
                else failed_next = 1'b1;
              end
              DM_PEQ: begin
                if (c == 8'h22) begin
                  dmode_next = DM_VALUE; {flb_next, flz_next, flq_next} = '0; nlen_next = '0;
                end else failed_next = 1'b1;
              end
              DM_VALUE: begin
                if (c == 8'h22) begin
                  {flb_next, flz_next, flq_next} = 3'b001; nlen_next = '0;
                end else if (c == 8'h20) begin
                  dmode_next = flb ? DM_ACCEPT : DM_VALUE;
                  {flb_next, flz_next, flq_next} = '0; nlen_next = '0;
                end else if (c == 8'h3D) begin
                  {flb_next, flz_next, flq_next} = '0; nlen_next = '0;
                end else begin
                  flb_next = bs_nb; flz_next = bs_nz; flq_next = 1'b0; nlen_next = bs_nm;
                end
              end
              default: failed_next = 1'b1;
            endcase
          end
          // Hostname, app name, process id, message id
          default: begin
            if (c == 8'h20) begin
              if (fpos != '0) begin
                fidx_next = field_t'(fidx + 3'd1); fpos_next = '0; hsub_next = '0;
                nlen_next = '0;
              end else failed_next = 1'b1;
            end else if (head.is_print && fpos < hlim) fpos_next = fpos + 8'd1;
            else failed_next = 1'b1;
          end
        endcase
      end
    end

    // Data part end check on the updated state
    unique case (dmode_next)
      DM_DASH, DM_ACCEPT:  end_ok = 1'b1;
      DM_PREFIX, DM_VALUE: end_ok = flb_next;
      default:             end_ok = 1'b0;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      host_max   <= svm_pkg::HOST_RST;
      app_max    <= svm_pkg::APP_RST;
      procid_max <= svm_pkg::PROCID_RST;
      msgid_max  <= svm_pkg::MSGID_RST;
      sdname_max <= svm_pkg::SDNAME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        svm_pkg::CFG_HOST:   host_max   <= cfg_data;
        svm_pkg::CFG_APP:    app_max    <= cfg_data;
        svm_pkg::CFG_PROCID: procid_max <= cfg_data;
        svm_pkg::CFG_MSGID:  msgid_max  <= cfg_data;
        svm_pkg::CFG_SDNAME: sdname_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // Parser state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      fidx <= F_PRI; fpos <= '0; hsub <= '0; pval <= '0;
      dmode <= DM_START; flb <= 1'b0; flz <= 1'b0; flq <= 1'b0;
      nlen <= '0; failed <= 1'b0;
      res_valid <= 1'b0; res_value <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (pop) begin
        if (head.is_last) begin
          res_valid <= 1'b1;
          res_value <= !failed_next && (fidx_next == F_DATA) && end_ok;
          fidx <= F_PRI; fpos <= '0; hsub <= '0; pval <= '0;
          dmode <= DM_START; flb <= 1'b0; flz <= 1'b0; flq <= 1'b0;
          nlen <= '0; failed <= 1'b0;
        end else begin
          fidx <= fidx_next; fpos <= fpos_next; hsub <= hsub_next; pval <= pval_next;
          dmode <= dmode_next; flb <= flb_next; flz <= flz_next; flq <= flq_next;
          nlen <= nlen_next; failed <= failed_next;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/syslog_message_validator_top.sv
// Top level of the syslog message validator: queue front, checker back end.
//
//   channel   dir  beat contents
//   msg_in    in   msg_byte[7:0], is_last
//   res_out   out  valid_res
//   cfg       in   index[2:0], data[7:0]
//
// One byte per cycle sustained while results are taken; an accepted byte is
// written into the four-entry queue, then checked when the checker pops it from
// the queue head, where the result register loads on a last byte.
// The checker's single-step grammar update sets the rate.
// Reset is synchronous; it restores register defaults and clears the parse.
// A stalled result holds the checker; bytes keep queuing until the queue fills.
module syslog_message_validator_top #(
  parameter int unsigned LONGEST_FIELD = 255
) (
  input logic       clk,
  input logic       rst,
  svm_in_if.sink    msg_in,
  svm_out_if.source res_out,
  svm_cfg_if.sink   cfg
);

  svm_pkg::item_t  head;
  svm_pkg::qstat_t qstat;
  logic            pop;

  assign cfg.ready = 1'b1;

  svm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (msg_in.valid),
    .in_ready (msg_in.ready),
    .in_byte  (msg_in.msg_byte),
    .in_last  (msg_in.is_last),
    .pop      (pop),
    .head     (head),
    .stat     (qstat)
  );

  svm_core #(.LONGEST_FIELD(LONGEST_FIELD)) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .head_valid (!qstat.empty),
    .head       (head),
    .pop        (pop),
    .res_valid  (res_out.valid),
    .res_ready  (res_out.ready),
    .res_value  (res_out.valid_res)
  );

`ifndef SYNTHESIS
  // Input back-pressure only when the queue is full
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !msg_in.ready |-> qstat.full) else $error("input stalled with queue space");

  // Never pop an empty queue
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    qstat.empty |-> !pop) else $error("pop from empty queue");

  // A stalled result blocks the checker
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (res_out.valid && !res_out.ready) |-> !pop) else $error("checker ran past stalled result");

  // Reset leaves no result pending
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !res_out.valid) else $error("result valid after reset");
`endif

endmodule

FILE: dv/tb_top.sv
// Testbench for the syslog message validator: directed and random messages vs a predictor.
module tb_top;

  typedef logic [svm_pkg::CFG_IDX_W-1:0] cfg_idx_t;

  logic clk;
  logic rst;
  int unsigned cycle_cnt;
  int unsigned fail_cnt;
  int unsigned base_gap;

  svm_in_if  msg_in ();
  svm_out_if res_out ();
  svm_cfg_if cfg ();

  syslog_message_validator_top dut (
    .clk(clk),
    .rst(rst),
    .msg_in(msg_in),
    .res_out(res_out),
    .cfg(cfg)
  );

  // Data-part modes and flags
  localparam logic [2:0] DM_START = 3'd0, DM_DASH = 3'd1, DM_ACCEPT = 3'd2, DM_PREFIX = 3'd3;
  localparam logic [2:0] DM_PNAME = 3'd4, DM_PEQ = 3'd5, DM_VALUE = 3'd6;
  localparam logic [7:0] FL_B = 8'd8, FL_Z = 8'd16, FL_Q = 8'd32;

  // Header field indexes
  localparam logic [2:0] F_PRI = 3'd0, F_VER = 3'd1, F_TIME = 3'd2, F_HOST = 3'd3;
  localparam logic [2:0] F_APP = 3'd4, F_PROCID = 3'd5, F_MSGID = 3'd6, F_DATA = 3'd7;

  // Timestamp phases
  localparam logic [5:0] TS_DASH = 6'd1, TS_FRAC = 6'd2;
  localparam logic [5:0] TS_OFFSET = 6'd3, TS_DONE = 6'd4;

  // Predictor copy of the registers and parse state
  logic [7:0] max_len [5];
  logic [2:0] fld;
  logic [7:0] fpos;
  logic [5:0] sub;
  logic [7:0] prev_val;
  logic [7:0] dbits;
  logic [7:0] nlen;
  logic       msg_bad;

  bit expected_valid [$];

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [7:0] lim_of(int idx);
    return max_len[idx];
  endfunction

  function automatic void clear_parse();
    fld = F_PRI; fpos = 0; sub = 0; prev_val = 0; dbits = 0; nlen = 0; msg_bad = 1'b0;
  endfunction

  function automatic void advance_field();
    fld = fld + 3'd1; fpos = 0; sub = 0; nlen = 0;
  endfunction

  function automatic void set_mode(logic [2:0] m, logic [7:0] fl);
    dbits = {5'd0, m} | fl; nlen = 0;
  endfunction

  // Block tracker for "[name]" runs; returns 1 while some split survives
  function automatic bit blocks_step(logic [7:0] c, logic [7:0] lim, bit q);
    logic [7:0] f, m, nm;
    bit nb, nz;
    f = dbits; m = nlen;
    nb = c == "]" && (m >= 1 || q);
    nz = (f & FL_B) != 0 && c == "[";
    if ((f & FL_Z) != 0) nm = lim >= 1 ? 8'd1 : 8'd0;
    else nm = (m >= 1 && m < lim) ? m + 8'd1 : 8'd0;
    dbits = (f & 8'd7) | (nb ? FL_B : 8'd0) | (nz ? FL_Z : 8'd0);
    nlen = nm;
    return nb || nz || nm != 0;
  endfunction

  function automatic void pri_byte(logic [7:0] c);
    int v;
    if (fpos == 0) begin
      if (c == "<") fpos = 8'd1; else msg_bad = 1;
    end else if (c == ">") begin
      if (sub >= 1) advance_field(); else msg_bad = 1;
    end else if (is_digit(c)) begin
      if (sub == 0) begin
        prev_val = c - "0"; sub = 6'd1;
      end else if (sub >= 3 || prev_val == 0) msg_bad = 1;
      else begin
        v = int'(prev_val) * 10 + int'(c - "0");
        if (v > 191) msg_bad = 1;
        else begin
          prev_val = 8'(v); sub = sub + 6'd1;
        end
      end
    end else msg_bad = 1;
  endfunction

  function automatic void version_byte(logic [7:0] c);
    if (is_digit(c)) begin
      if ((fpos == 0 && c == "0") || fpos >= 3) msg_bad = 1; else fpos = fpos + 8'd1;
    end else if (c == " " && fpos >= 1) advance_field();
    else msg_bad = 1;
  endfunction

  function automatic void time_byte(logic [7:0] c);
    bit ok;
    logic [7:0] q;
    ok = 0;
    if (sub == TS_DASH || sub == TS_DONE) begin
      if (c == " ") advance_field(); else msg_bad = 1;
      return;
    end
    if (sub == TS_FRAC) begin
      if (is_digit(c) && nlen < 6) nlen = nlen + 8'd1;
      else if (nlen >= 1 && c == "Z") sub = TS_DONE;
      else if (nlen >= 1 && (c == "+" || c == "-")) begin
        sub = TS_OFFSET; nlen = 0;
      end else msg_bad = 1;
      return;
    end
    if (sub == TS_OFFSET) begin
      q = nlen;
      if (q == 0) ok = c >= "0" && c <= "2";
      else if (q == 1) ok = is_digit(c) && (prev_val != 2 || c <= "3");
      else if (q == 2) ok = c == ":";
      else if (q == 3) ok = c >= "0" && c <= "5";
      else ok = is_digit(c);
      if (!ok) begin
        msg_bad = 1; return;
      end
      prev_val = c - "0";
      if (q >= 4) sub = TS_DONE; else nlen = q + 8'd1;
      return;
    end
    if (fpos == 0 && c == "-") begin
      sub = TS_DASH; return;
    end
    case (fpos)
      4, 7: ok = c == "-";
      5: ok = c == "0" || c == "1";
      6: ok = is_digit(c) && (prev_val == 0 ? c != "0" : c <= "2");
      8: ok = c >= "0" && c <= "3";
      9: ok = is_digit(c) && (prev_val != 3 || c <= "1");
      10: ok = c == "T";
      11: ok = c >= "0" && c <= "2";
      12: ok = is_digit(c) && (prev_val != 2 || c <= "3");
      13, 16: ok = c == ":";
      14, 17: ok = c >= "0" && c <= "5";
      19: begin
        if (c == ".") begin
          sub = TS_FRAC; nlen = 0;
        end else if (c == "Z") sub = TS_DONE;
        else if (c == "+" || c == "-") begin
          sub = TS_OFFSET; nlen = 0;
        end else msg_bad = 1;
        return;
      end
      default: ok = is_digit(c);
    endcase
    if (!ok) begin
      msg_bad = 1; return;
    end
    prev_val = c - "0";
    fpos = fpos + 8'd1;
  endfunction

  function automatic void name_byte(logic [7:0] c);
    logic [7:0] lim;
    lim = lim_of(int'(fld - F_HOST));
    if (c == " ") begin
      if (fpos >= 1) advance_field(); else msg_bad = 1;
    end else if (c >= 8'h21 && c <= 8'h7E && fpos < lim) fpos = fpos + 8'd1;
    else msg_bad = 1;
  endfunction

  function automatic void data_byte(logic [7:0] c);
    logic [7:0] lim, f;
    lim = lim_of(int'(svm_pkg::CFG_SDNAME));
    f = dbits;
    case (f[2:0])
      DM_START: begin
        if (c == "-") set_mode(DM_DASH, 0);
        else if (c == "[") set_mode(DM_PREFIX, FL_Z);
        else msg_bad = 1;
      end
      DM_DASH: begin
        if (c == " ") set_mode(DM_ACCEPT, 0); else msg_bad = 1;
      end
      DM_ACCEPT: ;
      DM_PREFIX: begin
        if (c == " ") begin
          if ((f & FL_B) != 0) set_mode(DM_ACCEPT, 0);
          else if (nlen >= 1) set_mode(DM_PNAME, 0);
          else msg_bad = 1;
        end else if (c == "=" || c == "\"") msg_bad = 1;
        else if (!blocks_step(c, lim, 0)) msg_bad = 1;
      end
      DM_PNAME: begin
        if (c == "=" && nlen >= 1) set_mode(DM_PEQ, 0);
        else if (c == " " || c == "\"" || c == "=") msg_bad = 1;
        else if (nlen < lim) nlen = nlen + 8'd1;
        else msg_bad = 1;
      end
      DM_PEQ: begin
        if (c == "\"") set_mode(DM_VALUE, 0); else msg_bad = 1;
      end
      DM_VALUE: begin
        if (c == "\"") set_mode(DM_VALUE, FL_Q);
        else if (c == " ") set_mode((f & FL_B) != 0 ? DM_ACCEPT : DM_VALUE, 0);
        else if (c == "=") set_mode(DM_VALUE, 0);
        else void'(blocks_step(c, lim, (f & FL_Q) != 0));
      end
      default: msg_bad = 1;
    endcase
  endfunction

  function automatic bit data_done_ok();
    case (dbits[2:0])
      DM_DASH, DM_ACCEPT: return 1;
      DM_PREFIX, DM_VALUE: return (dbits & FL_B) != 0;
      default: return 0;
    endcase
  endfunction

  // Advance the predictor by one byte; queue the verdict on the last byte
  function automatic void predict_byte(logic [7:0] c, bit last);
    if (!msg_bad) begin
      if (c == 0) msg_bad = 1;
      else if (fld == F_PRI) pri_byte(c);
      else if (fld == F_VER) version_byte(c);
      else if (fld == F_TIME) time_byte(c);
      else if (fld <= F_MSGID) name_byte(c);
      else data_byte(c);
    end
    if (last) begin
      expected_valid.push_back(!msg_bad && fld == F_DATA && data_done_ok());
      clear_parse();
    end
  endfunction

  function automatic int pick_gap(int bias);
    int r;
    r = $urandom_range(0, 99);
    if (r < bias) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Send one beat, then an optional random gap
  task automatic send_byte(logic [7:0] c, bit last);
    int g;
    msg_in.valid <= 1'b1;
    msg_in.msg_byte <= c;
    msg_in.is_last <= last;
    @(posedge clk);
    while (!msg_in.ready) @(posedge clk);
    predict_byte(c, last);
    g = pick_gap(base_gap);
    if (g > 0) begin
      msg_in.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_msg(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic wait_drained();
    msg_in.valid <= 1'b0;
    @(posedge clk);
    while (expected_valid.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    max_len[idx] = val;
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result checker with a random-stall sink
  always @(posedge clk) begin
    if (rst) begin
      res_out.ready <= 1'b0;
    end else begin
      if (res_out.valid && res_out.ready) begin
        if (expected_valid.size() == 0) begin
          $error("unexpected result valid_res=%0b", res_out.valid_res);
          fail_cnt++;
        end else begin
          if (res_out.valid_res !== expected_valid[0]) begin
            $error("valid_res mismatch: expected %0b actual %0b", expected_valid[0],
                   res_out.valid_res);
            fail_cnt++;
          end
          void'(expected_valid.pop_front());
        end
      end
      res_out.ready <= pick_gap(base_gap) == 0;
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic string rand_print(int n, bit no_sd);
    string s;
    byte c;
    s = "";
    for (int i = 0; i < n; i++) begin
      do c = byte'($urandom_range(8'h21, 8'h7E));
      while (no_sd && (c == "=" || c == "\"" || c == "]"));
      s = {s, string'(c)};
    end
    return s;
  endfunction

  function automatic string rand_digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range("0", "9")))};
    return s;
  endfunction

  function automatic string rand_time();
    string s;
    if ($urandom_range(0, 4) == 0) return "-";
    s = $sformatf("%04d-%02d-%02dT%02d:%02d:%02d", $urandom_range(1, 9999),
                  $urandom_range(1, 12), $urandom_range(0, 31), $urandom_range(0, 23),
                  $urandom_range(0, 59), $urandom_range(0, 59));
    if ($urandom_range(0, 1)) s = {s, ".", rand_digits($urandom_range(1, 6))};
    case ($urandom_range(0, 2))
      0: s = {s, "Z"};
      1: s = {s, $sformatf("+%02d:%02d", $urandom_range(0, 23), $urandom_range(0, 59))};
      default: s = {s, $sformatf("-%02d:%02d", $urandom_range(0, 23), $urandom_range(0, 59))};
    endcase
    return s;
  endfunction

  function automatic string rand_sd();
    string s;
    if ($urandom_range(0, 3) == 0) return "-";
    s = "";
    repeat ($urandom_range(1, 2)) begin
      s = {s, "[", rand_print($urandom_range(1, 6), 1)};
      repeat ($urandom_range(0, 2))
        s = {s, " ", rand_print($urandom_range(1, 5), 1), "=\"",
             rand_print($urandom_range(0, 6), 1), "\""};
      s = {s, "]"};
    end
    return s;
  endfunction

  // A well-formed message with random content
  function automatic string rand_message();
    string s;
    s = {"<", $sformatf("%0d", $urandom_range(0, 191)), ">",
         $sformatf("%0d", $urandom_range(1, 999)), " ", rand_time(), " ",
         rand_print($urandom_range(1, 8), 0), " ", rand_print($urandom_range(1, 8), 0), " ",
         rand_print($urandom_range(1, 6), 0), " ", rand_print($urandom_range(1, 6), 0), " ",
         rand_sd()};
    if ($urandom_range(0, 1)) s = {s, " ", rand_print($urandom_range(0, 8), 0)};
    return s;
  endfunction

  // Corrupt a message: flip a byte to anything, including zero, or cut it short
  task automatic send_damaged(string s);
    int pos, cut;
    byte c;
    pos = $urandom_range(0, s.len() - 1);
    cut = $urandom_range(0, 3) == 0 ? $urandom_range(1, s.len()) : s.len();
    for (int i = 0; i < cut; i++) begin
      c = s[i];
      if (i == pos) c = byte'($urandom_range(0, 255));
      send_byte(c, i == cut - 1);
    end
  endtask

  task automatic test_directed();
    send_msg("<0>1 - - - - - -");
    send_msg("<191>999 2023-12-31T23:59:59.123456+23:59 h a p m [id@1 k=\"v\"] hi");
    send_msg("<192>1 - - - - - -");
    send_msg("<105>1 2000-01-00T00:00:00Z - - - - -");
    send_msg("<01>1 - - - - - -");
    send_msg("<1>0 - - - - - -");
    send_msg("<1>1 2000-01-01T00:00:00.1234567Z - - - - -");
    send_msg("<1>1 - - - - -");
    send_msg("<1>1 - - - - - ");
    send_msg("<1>1 - - - - [a][b=x]");
    send_msg("<1>1 - - - - [a k=\"x]\"] rest");
    send_msg("<1>1 - - - - [a k=\"v\"");
    send_msg("<1>1 - - - - - \xff\x80 x");
    send_byte(8'h00, 1'b1);
    send_byte("<", 1'b1);
  endtask

  task automatic test_register_limits();
    string s255;
    wait_drained();
    s255 = rand_print(255, 0);
    for (int i = 0; i < 5; i++) write_reg(cfg_idx_t'(i), 8'd1);
    send_msg("<1>1 - h a p m [x y=\"1\"]");
    send_msg("<1>1 - hh a p m -");
    send_msg("<1>1 - - - - - [xy]");
    wait_drained();
    for (int i = 0; i < 5; i++) write_reg(cfg_idx_t'(i), 8'd255);
    send_msg({"<1>1 - ", s255, " a p m -"});
    send_msg({"<1>1 - ", s255, "x a p m -"});
    wait_drained();
    for (int i = 0; i < 5; i++) write_reg(cfg_idx_t'(i), 8'd0);
    send_msg("<1>1 - h a p m -");
    wait_drained();
    for (int i = 0; i < 5; i++) write_reg(cfg_idx_t'(i), 8'($urandom_range(3, 6)));
  endtask

  task automatic test_random(int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      string s;
      s = rand_message();
      if ($urandom_range(0, 9) < 7) send_msg(s); else send_damaged(s);
      sent += s.len();
      if ($urandom_range(0, 29) == 0) base_gap = $urandom_range(0, 1) ? 100 : 60;
      if ($urandom_range(0, 39) == 0) begin
        wait_drained();
        for (int i = 0; i < 5; i++) write_reg(cfg_idx_t'(i), 8'($urandom_range(1, 10)));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    msg_in.valid = 1'b0;
    msg_in.msg_byte = 8'h00;
    msg_in.is_last = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = svm_pkg::CFG_HOST;
    cfg.data = 8'h00;
    cycle_cnt = 0;
    fail_cnt = 0;
    base_gap = 60;
    max_len[svm_pkg::CFG_HOST] = svm_pkg::HOST_RST;
    max_len[svm_pkg::CFG_APP] = svm_pkg::APP_RST;
    max_len[svm_pkg::CFG_PROCID] = svm_pkg::PROCID_RST;
    max_len[svm_pkg::CFG_MSGID] = svm_pkg::MSGID_RST;
    max_len[svm_pkg::CFG_SDNAME] = svm_pkg::SDNAME_RST;
    clear_parse();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_limits();
    test_random(300);
    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_cnt == 0 && expected_valid.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
